// ===== rtl/rle_sprite_line_blitter_assert.svh =====
// Assertion macros shared by the blitter modules.
`ifndef RLE_SPRITE_LINE_BLITTER_ASSERT_SVH
`define RLE_SPRITE_LINE_BLITTER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RSB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define RSB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rsb_pkg.sv =====
// Package: types and constants of the RLE sprite line blitter.
`timescale 1ns / 1ps
package rsb_pkg;
	localparam int CW     = 14;  // signed coordinate width for clipping
	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_POS_X = 2'd0,
		REG_POS_Y = 2'd1,
		REG_FLIP  = 2'd2
	} rsb_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLAG_HI,
		ST_WIDTH,
		ST_HEIGHT,
		ST_CLIP,
		ST_ADDR,
		ST_CHUNKS,
		ST_SKIP,
		ST_CNT_HI,
		ST_CNT_LO,
		ST_LITERAL,
		ST_TRAIL,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} rsb_state_t;

	typedef struct packed {
		logic load_flag_lo;
		logic load_flag_hi;
		logic load_width;
		logic load_height;
		logic do_clip;
		logic do_addr;
		logic load_chunks;
		logic chunk_dec;
		logic do_skip;
		logic load_cnt_hi;
		logic load_cnt_lo;
		logic do_literal;
		logic trail_skip;
		logic trail_draw;
		logic line_clear;
		logic next_line;
		logic emit_start;
		logic emit_read;
		logic emit_load;
	} rsb_cmd_t;

	typedef struct packed {
		logic drop;
		logic byte_zero;
		logic cnt_zero;
		logic lit_last;
		logic chunk_last;
		logic lskip_pos;
		logic ldraw_one;
		logic ldraw_zero;
		logic vis_zero;
		logic group_last;
		logic out_free;
	} rsb_status_t;
endpackage

// ===== rtl/rsb_ifs.sv =====
// Channel interfaces: byte stream in, pixel groups out, register writes.
`timescale 1ns / 1ps
interface rsb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       frame_start;
	modport source (output valid, output stream_byte, output frame_start, input ready);
	modport sink   (input valid, input stream_byte, input frame_start, output ready);
endinterface

interface rsb_group_if;
	logic        valid;
	logic        ready;
	logic [15:0] dest_address;
	logic [63:0] pixel_group;
	logic [7:0]  byte_enable;
	logic        line_end;
	logic        frame_end;
	modport source (output valid, output dest_address, output pixel_group,
		output byte_enable, output line_end, output frame_end, input ready);
	modport sink   (input valid, input dest_address, input pixel_group,
		input byte_enable, input line_end, input frame_end, output ready);
endinterface

interface rsb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [11:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rsb_ctrl.sv =====
// Controller: stream parse and line emission state machine.
`timescale 1ns / 1ps
`include "rle_sprite_line_blitter_assert.svh"
module rsb_ctrl import rsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        frame_start,
	output logic        in_ready,
	output rsb_cmd_t    cmd,
	input  rsb_status_t st
);
	rsb_state_t state_q, state_d;
	logic acc;

	always_comb begin
		case (state_q)
			ST_CLIP, ST_ADDR, ST_EMIT_RD, ST_EMIT_OUT: in_ready = 1'b0;
			default: in_ready = 1'b1;
		endcase
	end

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		if (acc && frame_start) begin
			state_d = ST_FLAG_HI;
		end else begin
			case (state_q)
				ST_FLAG_HI: if (acc) state_d = ST_WIDTH;
				ST_WIDTH:   if (acc) state_d = ST_HEIGHT;
				ST_HEIGHT:  if (acc) state_d = ST_CLIP;
				ST_CLIP:    state_d = st.drop ? ST_IDLE : ST_ADDR;
				ST_ADDR:    state_d = ST_CHUNKS;
				ST_CHUNKS:  if (acc) state_d = st.byte_zero ? ST_TRAIL : ST_SKIP;
				ST_SKIP:    if (acc) state_d = ST_CNT_HI;
				ST_CNT_HI:  if (acc) state_d = ST_CNT_LO;
				ST_CNT_LO: begin
					if (acc) begin
						if (!st.cnt_zero) state_d = ST_LITERAL;
						else state_d = st.chunk_last ? ST_TRAIL : ST_SKIP;
					end
				end
				ST_LITERAL: begin
					if (acc && st.lit_last) state_d = st.chunk_last ? ST_TRAIL : ST_SKIP;
				end
				ST_TRAIL: begin
					if (acc) begin
						if (st.lskip_pos) state_d = ST_CHUNKS;
						else if (st.vis_zero) state_d = st.ldraw_one ? ST_IDLE : ST_CHUNKS;
						else state_d = ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: state_d = ST_EMIT_OUT;
				ST_EMIT_OUT: begin
					if (st.out_free) begin
						if (!st.group_last) state_d = ST_EMIT_RD;
						else state_d = st.ldraw_zero ? ST_IDLE : ST_CHUNKS;
					end
				end
				default: state_d = state_q;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		if (acc && frame_start) begin
			cmd.load_flag_lo = 1'b1;
		end else begin
			case (state_q)
				ST_FLAG_HI: cmd.load_flag_hi = acc;
				ST_WIDTH:   cmd.load_width   = acc;
				ST_HEIGHT:  cmd.load_height  = acc;
				ST_CLIP:    cmd.do_clip      = !st.drop;
				ST_ADDR: begin
					cmd.do_addr    = 1'b1;
					cmd.line_clear = 1'b1;
				end
				ST_CHUNKS:  cmd.load_chunks  = acc;
				ST_SKIP:    cmd.do_skip      = acc;
				ST_CNT_HI:  cmd.load_cnt_hi  = acc;
				ST_CNT_LO: begin
					cmd.load_cnt_lo = acc;
					cmd.chunk_dec   = acc && st.cnt_zero;
				end
				ST_LITERAL: begin
					cmd.do_literal = acc;
					cmd.chunk_dec  = acc && st.lit_last;
				end
				ST_TRAIL: begin
					if (acc) begin
						if (st.lskip_pos) begin
							cmd.trail_skip = 1'b1;
							cmd.line_clear = 1'b1;
						end else begin
							cmd.trail_draw = 1'b1;
							cmd.line_clear = st.vis_zero;
							cmd.next_line  = st.vis_zero;
							cmd.emit_start = !st.vis_zero;
						end
					end
				end
				ST_EMIT_RD: cmd.emit_read = 1'b1;
				ST_EMIT_OUT: begin
					cmd.emit_load  = st.out_free;
					cmd.line_clear = st.out_free && st.group_last;
					cmd.next_line  = st.out_free && st.group_last;
				end
				default: cmd = '0;
			endcase
		end
	end

	`RSB_ASSERT_NXT(a_hdr_clip, acc && !frame_start && state_q == ST_HEIGHT,
		state_q == ST_CLIP, "height byte did not start clipping")
	`RSB_ASSERT_NXT(a_rd_out, state_q == ST_EMIT_RD, state_q == ST_EMIT_OUT,
		"group read not followed by output stage")
	`RSB_ASSERT_NXT(a_line_done, cmd.emit_load && st.group_last,
		state_q == ST_CHUNKS || state_q == ST_IDLE, "line end left emission running")
endmodule

// ===== rtl/rsb_dp.sv =====
// Datapath: header and clip registers, chunk counters, line store, group builder.
`timescale 1ns / 1ps
`include "rle_sprite_line_blitter_assert.svh"
module rsb_dp import rsb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        byte_in,
	input  rsb_cmd_t          cmd,
	output rsb_status_t       st,
	rsb_group_if.source       groups,
	rsb_cfg_if.sink           cfg
);
	localparam int W    = SCREEN_WIDTH;
	localparam int H    = SCREEN_HEIGHT;
	localparam int ROWS = (W + 7) / 8;
	localparam int RIW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WCW  = $clog2(W + 1);
	localparam int HCW  = $clog2(H + 1);
	localparam int BW   = $clog2(W + 8);

	// configuration
	logic signed [11:0] pos_x_q, pos_y_q;
	logic               flip_req_q;
	// header
	logic [15:0]          flag_q;
	logic [7:0]           wb_q;
	logic signed [CW-1:0] x_q, y_q, h_q, w0_q;
	logic                 flip_q;
	// clip results
	logic [11:0]          lskip_q, skip_q;
	logic [HCW-1:0]       ldraw_q, y2_q;
	logic [WCW-1:0]       x2_q, vis_q;
	logic signed [CW-1:0] fbase_q;
	logic [15:0]          line_addr_q;
	// chunk counters
	logic [7:0]     chunks_q, cnt_hi_q;
	logic [10:0]    lit_q;
	logic [WCW-1:0] wcol_q;
	// line store
	logic [63:0]     mem [ROWS];
	logic [ROWS-1:0] row_valid_q;
	logic [63:0]     rd0_q, rd1_q;
	logic            v0_q, v1_q;
	logic [2:0]      off_q;
	logic [BW-1:0]   base_q;
	// output
	logic        out_valid_q;
	logic [15:0] o_addr_q;
	logic [63:0] o_pix_q;
	logic [7:0]  o_en_q;
	logic        o_le_q, o_fe_q;

	// clipping
	logic signed [CW-1:0] w1, h1, h2, ls, y2, sk, x2, w0n;
	logic                 drop;
	logic [10:0]          cnt_total;
	logic [11:0]          skip_sum;
	logic signed [CW-1:0] s, r0, r1;
	logic                 in0, in1;
	logic [127:0]         win;
	logic [63:0]          pix;
	logic [7:0]           en;
	logic [BW:0]          base_next;
	logic [RIW-1:0]       wrow;
	logic [2:0]           wlane;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			flip_req_q <= 1'b0;
		end else if (cfg.valid) begin
			case (rsb_reg_t'(cfg.index))
				REG_POS_X: pos_x_q    <= cfg.data;
				REG_POS_Y: pos_y_q    <= cfg.data;
				REG_FLIP:  flip_req_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w1 = ((x_q + w0_q) >= CW'(W)) ? (CW'(W) - x_q) : w0_q;
		h1 = ((y_q + h_q) >= CW'(H)) ? (CW'(H) - y_q) : h_q;
		h2 = (y_q < 0) ? (h1 + y_q) : h1;
		ls = (y_q < 0) ? -y_q : '0;
		y2 = (y_q < 0) ? '0 : y_q;
		sk = (x_q < 0) ? -x_q : '0;
		x2 = (x_q < 0) ? '0 : x_q;
		drop = ((y_q < 0) && ((y_q + h1 - 1) < 0)) || ((x_q < 0) && ((x_q + w1 - 1) < 0))
			|| (x2 >= CW'(W)) || (y2 >= CW'(H)) || (h2 <= 0);
		w0n = (CW'({wb_q, 4'b0}) > CW'(W)) ? CW'(W) : CW'({wb_q, 4'b0});
	end

	assign cnt_total = {1'b0, cnt_hi_q, 2'b0} + 11'(byte_in);
	assign skip_sum  = 12'(wcol_q) + 12'(byte_in);
	assign base_next = (BW+1)'(base_q) + (BW+1)'(8);

	always_ff @(posedge clk) begin
		if (cmd.load_flag_lo) flag_q[7:0]  <= byte_in;
		if (cmd.load_flag_hi) flag_q[15:8] <= byte_in;
		if (cmd.load_width)   wb_q <= byte_in;
		if (cmd.load_height) begin
			x_q    <= CW'(pos_x_q);
			y_q    <= CW'(pos_y_q) - CW'({1'b0, byte_in}) + CW'(1);
			h_q    <= CW'({1'b0, byte_in});
			w0_q   <= w0n;
			flip_q <= flip_req_q ^ flag_q[15];
		end
		if (cmd.do_clip) begin
			lskip_q <= 12'(ls);
			skip_q  <= 12'(sk);
			y2_q    <= HCW'(y2);
			x2_q    <= WCW'(x2);
			vis_q   <= WCW'(w1 - sk);
			fbase_q <= w0_q - CW'(8) - sk;
		end else if (cmd.trail_skip) begin
			lskip_q <= lskip_q - 12'd1;
		end
		if (cmd.do_addr) line_addr_q <= 16'(32'(y2_q) * 32'(W) + 32'(x2_q));
		else if (cmd.next_line) line_addr_q <= line_addr_q + 16'(W);
		if (cmd.load_chunks) chunks_q <= byte_in;
		else if (cmd.chunk_dec) chunks_q <= chunks_q - 8'd1;
		if (cmd.load_cnt_hi) cnt_hi_q <= byte_in;
		if (cmd.load_cnt_lo) lit_q <= cnt_total;
		else if (cmd.do_literal) lit_q <= lit_q - 11'd1;
		if (cmd.emit_start) base_q <= '0;
		else if (cmd.emit_load) base_q <= BW'(base_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ldraw_q <= '0;
		end else if (cmd.do_clip) begin
			ldraw_q <= HCW'(h2);
		end else if (cmd.trail_draw) begin
			ldraw_q <= ldraw_q - HCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcol_q <= '0;
		end else if (cmd.line_clear) begin
			wcol_q <= '0;
		end else if (cmd.do_skip) begin
			wcol_q <= (skip_sum > 12'(W)) ? WCW'(W) : WCW'(skip_sum);
		end else if (cmd.do_literal && (wcol_q < WCW'(W))) begin
			wcol_q <= wcol_q + WCW'(1);
		end
	end

	// line store: a row's first write zero-fills the rest of it
	assign wrow  = RIW'(wcol_q >> 3);
	assign wlane = wcol_q[2:0];

	always_ff @(posedge clk) begin
		if (cmd.do_literal && (wcol_q < WCW'(W))) begin
			for (int k = 0; k < 8; k++) begin
				if (k == int'(wlane)) mem[wrow][k*8 +: 8] <= byte_in;
				else if (!row_valid_q[wrow]) mem[wrow][k*8 +: 8] <= 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.line_clear) begin
			row_valid_q <= '0;
		end else if (cmd.do_literal && (wcol_q < WCW'(W))) begin
			row_valid_q[wrow] <= 1'b1;
		end
	end

	// group read: two rows around the window start
	always_comb begin
		s   = flip_q ? (fbase_q - CW'(base_q)) : (CW'(skip_q) + CW'(base_q));
		r0  = s >>> 3;
		r1  = r0 + CW'(1);
		in0 = (r0 >= 0) && (r0 < CW'(ROWS));
		in1 = (r1 >= 0) && (r1 < CW'(ROWS));
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_read) begin
			rd0_q <= mem[r0[RIW-1:0]];
			rd1_q <= mem[r1[RIW-1:0]];
			v0_q  <= in0 && row_valid_q[r0[RIW-1:0]];
			v1_q  <= in1 && row_valid_q[r1[RIW-1:0]];
			off_q <= s[2:0];
		end
	end

	always_comb begin
		logic [3:0] k;
		win = {v1_q ? rd1_q : 64'd0, v0_q ? rd0_q : 64'd0};
		pix = '0;
		en  = '0;
		for (int i = 0; i < 8; i++) begin
			k = flip_q ? (4'(off_q) + 4'(7 - i)) : (4'(off_q) + 4'(i));
			if (((BW+1)'(base_q) + (BW+1)'(i)) < (BW+1)'(vis_q)) begin
				pix[i*8 +: 8] = win[k*8 +: 8];
			end
			en[i] = (pix[i*8 +: 8] != 8'h00);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (groups.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			o_addr_q <= line_addr_q + 16'(base_q);
			o_pix_q  <= pix;
			o_en_q   <= en;
			o_le_q   <= st.group_last;
			o_fe_q   <= st.group_last && (ldraw_q == '0);
		end
	end

	assign groups.valid        = out_valid_q;
	assign groups.dest_address = o_addr_q;
	assign groups.pixel_group  = o_pix_q;
	assign groups.byte_enable  = o_en_q;
	assign groups.line_end     = o_le_q;
	assign groups.frame_end    = o_fe_q;

	always_comb begin
		st.drop       = drop;
		st.byte_zero  = (byte_in == 8'd0);
		st.cnt_zero   = (cnt_total == 11'd0);
		st.lit_last   = (lit_q == 11'd1);
		st.chunk_last = (chunks_q == 8'd1);
		st.lskip_pos  = (lskip_q != 12'd0);
		st.ldraw_one  = (ldraw_q == HCW'(1));
		st.ldraw_zero = (ldraw_q == '0);
		st.vis_zero   = (vis_q == '0);
		st.group_last = (base_next >= (BW+1)'(vis_q));
		st.out_free   = !out_valid_q || groups.ready;
	end

	`RSB_ASSERT_IMP(a_load_free, cmd.emit_load, !out_valid_q || groups.ready,
		"group loaded over an untaken result")
	`RSB_ASSERT_IMP(a_wcol_max, 1'b1, wcol_q <= WCW'(W), "write column past line store")
	`RSB_ASSERT_NXT(a_clear, cmd.line_clear, row_valid_q == '0, "line store not cleared")
endmodule

// ===== rtl/rle_sprite_line_blitter.sv =====
// Top level of the RLE sprite line blitter.
// Channels: stream takes one frame byte per transaction (frame_start marks
// the low flag byte); groups returns one 8-pixel write per transaction;
// cfg writes pos_x, pos_y and flip_request by index, always ready.
// Each stream byte is taken when valid and ready are both high. The height
// byte is followed by the clip state and the row address state, both with
// stream.ready low (a dropped frame leaves the clip state for idle).
// The trailing byte of a drawn line starts the emission: each group takes
// a line store row read, then group assembly into the output register, up
// to (SCREEN_WIDTH+7)/8 groups, with stream.ready low until the last group
// is loaded. The first group leaves the output register after the row read
// and output states. The output register lets the next line be parsed while
// the last group waits; a stalled receiver holds the emission in place.
// Reset: idle for frame_start, cfg regs zero, no output, line store empty.
`timescale 1ns / 1ps
module rle_sprite_line_blitter import rsb_pkg::*; #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	rsb_byte_if.sink    stream,
	rsb_group_if.source groups,
	rsb_cfg_if.sink     cfg
);
	rsb_cmd_t    cmd;
	rsb_status_t st;
	logic        in_ready;

	assign stream.ready = in_ready;

	rsb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (stream.valid),
		.frame_start (stream.frame_start),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.st          (st)
	);

	rsb_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (stream.stream_byte),
		.cmd     (cmd),
		.st      (st),
		.groups  (groups),
		.cfg     (cfg)
	);
endmodule
